// File: rtl/core/gmkc_pkg.sv
// shared constants, codes and control types of the maze carver
package gmkc_pkg;

    localparam int GRID_SIDE      = 31;
    localparam int COORD_W        = 5;
    localparam int HALF_W         = COORD_W - 1;
    localparam int SUM_W          = COORD_W + 1;
    localparam int CELLS_PER_SIDE = (GRID_SIDE + 1) / 2;
    localparam int CELL_COUNT     = CELLS_PER_SIDE * CELLS_PER_SIDE;
    localparam int CELL_AW        = 2 * HALF_W;
    localparam int CELL_DEPTH     = 2 ** CELL_AW;
    localparam int WALL_AW        = CELL_AW + 1;
    localparam int WALL_DEPTH     = 2 ** WALL_AW;

    localparam logic [CELL_AW-1:0] MERGE_TARGET = CELL_AW'(CELL_COUNT - 1);

    localparam logic OP_CARVE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] DIR_ROW_PLUS  = 2'd0;
    localparam logic [1:0] DIR_COL_PLUS  = 2'd1;
    localparam logic [1:0] DIR_ROW_MINUS = 2'd2;
    localparam logic [1:0] DIR_COL_MINUS = 2'd3;

    // wall address type bit: odd-row walls sit between vertically adjacent cells
    localparam logic WALL_HORIZ = 1'b0;
    localparam logic WALL_VERT  = 1'b1;

    typedef enum logic [2:0] {
        ST_CARVED        = 3'd0,
        ST_OUT_OF_BOUNDS = 3'd1,
        ST_WALL_OPEN     = 3'd2,
        ST_SAME_GROUP    = 3'd3,
        ST_NOT_CELL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_SWEEP,
        S_COMMIT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic take;
        logic clear_step;
        logic lookup;
        logic check;
        logic sweep_step;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic carve_ok;
        logic sweep_done;
    } dp_sts_t;

endpackage

// File: rtl/core/gmkc_ctrl.sv
// controller state machine: clearing pass, item sequencing and result handshake
module gmkc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  gmkc_pkg::dp_sts_t    sts,
    output gmkc_pkg::ctrl_cmd_t  cmd
);
    import gmkc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.carve_ok ? S_SWEEP : S_RESULT;
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // output register frees up when empty or taken this edge
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// File: rtl/core/gmkc_datapath.sv
// datapath: item registers, wall and label memories, checks, relabel sweep, result register
module gmkc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gmkc_pkg::ctrl_cmd_t          cmd,
    output gmkc_pkg::dp_sts_t            sts,
    input  logic                         op,
    input  logic [gmkc_pkg::COORD_W-1:0] cell_row,
    input  logic [gmkc_pkg::COORD_W-1:0] cell_col,
    input  logic [1:0]                   direction,
    output logic [2:0]                   status,
    output logic                         location_open,
    output logic                         maze_complete
);
    import gmkc_pkg::*;

    // item registers
    logic               op_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic [1:0]         dir_reg;

    // memories
    logic [CELL_AW-1:0] lbl_mem [CELL_DEPTH];
    logic               wall_mem [WALL_DEPTH];
    logic [CELL_AW-1:0] lbl_a_q;
    logic [CELL_AW-1:0] lbl_b_q;
    logic               wall_q;

    // control counters
    logic [WALL_AW-1:0] clr_cnt_reg;
    logic [CELL_AW:0]   sweep_cnt_reg;
    logic               sweep_vld_reg;
    logic               sweep_vld_next;
    logic [CELL_AW-1:0] sweep_addr_reg;
    logic [CELL_AW-1:0] merges_reg;

    // merge labels and result
    logic [CELL_AW-1:0] hi_reg;
    logic [CELL_AW-1:0] lo_reg;
    status_t            res_status_reg;
    logic               res_open_reg;
    status_t            out_status_reg;
    logic               out_open_reg;
    logic               out_complete_reg;

    logic [HALF_W-1:0]  cell_a;
    logic [HALF_W-1:0]  cell_b;
    logic [CELL_AW-1:0] own_addr;
    logic [CELL_AW-1:0] far_addr;
    logic [WALL_AW-1:0] wall_addr;
    logic [CELL_AW-1:0] lbl_rd_addr;
    logic               in_grid;
    logic               is_cell;
    logic               far_ok;
    logic               open_calc;
    status_t            status_calc;
    logic               lbl_hit;

    assign cell_a   = row_reg[COORD_W-1:1];
    assign cell_b   = col_reg[COORD_W-1:1];
    assign own_addr = {cell_a, cell_b};
    assign in_grid  = (row_reg < COORD_W'(GRID_SIDE)) && (col_reg < COORD_W'(GRID_SIDE));
    assign is_cell  = !row_reg[0] && !col_reg[0];

    always_comb
    begin
        case (dir_reg)
            DIR_ROW_PLUS:
            begin
                far_addr = {HALF_W'(cell_a + 1'b1), cell_b};
                far_ok   = (SUM_W'({1'b0, row_reg}) + SUM_W'(2)) < SUM_W'(GRID_SIDE);
            end
            DIR_COL_PLUS:
            begin
                far_addr = {cell_a, HALF_W'(cell_b + 1'b1)};
                far_ok   = (SUM_W'({1'b0, col_reg}) + SUM_W'(2)) < SUM_W'(GRID_SIDE);
            end
            DIR_ROW_MINUS:
            begin
                far_addr = {HALF_W'(cell_a - 1'b1), cell_b};
                far_ok   = row_reg >= COORD_W'(2);
            end
            default:
            begin
                far_addr = {cell_a, HALF_W'(cell_b - 1'b1)};
                far_ok   = col_reg >= COORD_W'(2);
            end
        endcase
    end

    always_comb
    begin
        if (op_reg == OP_READ)
            wall_addr = {row_reg[0], cell_a, cell_b};
        else
        begin
            case (dir_reg)
                DIR_ROW_PLUS:  wall_addr = {WALL_VERT, cell_a, cell_b};
                DIR_COL_PLUS:  wall_addr = {WALL_HORIZ, cell_a, cell_b};
                DIR_ROW_MINUS: wall_addr = {WALL_VERT, HALF_W'(cell_a - 1'b1), cell_b};
                default:       wall_addr = {WALL_HORIZ, cell_a, HALF_W'(cell_b - 1'b1)};
            endcase
        end
    end

    // cells are always open, odd-odd corners never open
    assign open_calc = is_cell ? 1'b1 : ((row_reg[0] && col_reg[0]) ? 1'b0 : wall_q);

    always_comb
    begin
        if (op_reg == OP_READ)
            status_calc = in_grid ? ST_CARVED : ST_OUT_OF_BOUNDS;
        else if (!in_grid || !is_cell)
            status_calc = ST_NOT_CELL;
        else if (!far_ok)
            status_calc = ST_OUT_OF_BOUNDS;
        else if (wall_q)
            status_calc = ST_WALL_OPEN;
        else if (lbl_a_q == lbl_b_q)
            status_calc = ST_SAME_GROUP;
        else
            status_calc = ST_CARVED;
    end

    assign lbl_rd_addr = cmd.sweep_step ? sweep_cnt_reg[CELL_AW-1:0] : own_addr;
    assign lbl_hit     = sweep_vld_reg && (lbl_a_q == lo_reg);

    // label memory: two read ports, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.lookup || cmd.sweep_step)
            lbl_a_q <= lbl_mem[lbl_rd_addr];
        if (cmd.lookup)
            lbl_b_q <= lbl_mem[far_addr];
        if (cmd.clear_step && !clr_cnt_reg[WALL_AW-1])
            lbl_mem[clr_cnt_reg[CELL_AW-1:0]] <= clr_cnt_reg[CELL_AW-1:0];
        else if (lbl_hit)
            lbl_mem[sweep_addr_reg] <= hi_reg;
    end

    // wall open-bit memory
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
            wall_q <= wall_mem[wall_addr];
        if (cmd.clear_step)
            wall_mem[clr_cnt_reg] <= 1'b0;
        else if (cmd.commit)
            wall_mem[wall_addr] <= 1'b1;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= op;
            row_reg <= cell_row;
            col_reg <= cell_col;
            dir_reg <= direction;
        end
        if (cmd.check)
        begin
            res_status_reg <= status_calc;
            res_open_reg   <= (op_reg == OP_READ) && in_grid && open_calc;
            hi_reg         <= (lbl_a_q > lbl_b_q) ? lbl_a_q : lbl_b_q;
            lo_reg         <= (lbl_a_q > lbl_b_q) ? lbl_b_q : lbl_a_q;
        end
        sweep_addr_reg <= sweep_cnt_reg[CELL_AW-1:0];
        if (cmd.load_out)
        begin
            out_status_reg   <= res_status_reg;
            out_open_reg     <= res_open_reg;
            out_complete_reg <= merges_reg >= MERGE_TARGET;
        end
    end

    assign sweep_vld_next = cmd.sweep_step && !sweep_cnt_reg[CELL_AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            sweep_cnt_reg <= '0;
            sweep_vld_reg <= 1'b0;
            merges_reg    <= '0;
        end
        else
        begin
            sweep_vld_reg <= sweep_vld_next;
            if (cmd.clear_step)
                clr_cnt_reg <= WALL_AW'(clr_cnt_reg + 1'b1);
            if (cmd.check)
                sweep_cnt_reg <= '0;
            else if (sweep_vld_next)
                sweep_cnt_reg <= (CELL_AW + 1)'(sweep_cnt_reg + 1'b1);
            if (cmd.commit)
                merges_reg <= CELL_AW'(merges_reg + 1'b1);
        end
    end

    assign sts.clear_done = &clr_cnt_reg;
    assign sts.carve_ok   = (op_reg == OP_CARVE) && (status_calc == ST_CARVED);
    assign sts.sweep_done = sweep_cnt_reg[CELL_AW];

    assign status        = out_status_reg;
    assign location_open = out_open_reg;
    assign maze_complete = out_complete_reg;

endmodule

// File: rtl/core/grid_maze_kruskal_carver_unit.sv
// top level of the maze carver: controller plus datapath
//
//  channel  handshake                   beat fields
//  -------  --------------------------  ---------------------------------------
//  item     item_valid / item_stall     op, cell_row, cell_col, direction
//  result   result_valid / result_stall status, location_open, maze_complete
//
// a read or a rejected carve passes the lookup, check and result states before the next accept
// a carve that merges also runs the relabel sweep, which walks all 256 cell
// labels through one port of the label memory, one label per cycle
// after reset a clearing pass fills the wall and label memories, item_stall high
// one item at a time; a finished beat waits in the output register while the next
// item is taken
module grid_maze_kruskal_carver_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         op,
    input  logic [gmkc_pkg::COORD_W-1:0] cell_row,
    input  logic [gmkc_pkg::COORD_W-1:0] cell_col,
    input  logic [1:0]                   direction,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [2:0]                   status,
    output logic                         location_open,
    output logic                         maze_complete
);
    import gmkc_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    gmkc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    gmkc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .direction     (direction),
        .status        (status),
        .location_open (location_open),
        .maze_complete (maze_complete)
    );

endmodule

// File: verif/testbench.sv
// self-checking testbench for the grid maze kruskal carver unit
module testbench;
    import gmkc_pkg::*;

    localparam int LOC_COUNT   = GRID_SIDE * GRID_SIDE;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 2000;

    typedef struct {
        logic               op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [1:0]         dir;
        bit                 drain;
    } maze_req_t;

    typedef struct {
        status_t status;
        logic    location_open;
        logic    maze_complete;
    } maze_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               op = OP_CARVE;
    logic [COORD_W-1:0] cell_row = '0;
    logic [COORD_W-1:0] cell_col = '0;
    logic [1:0]         direction = DIR_ROW_PLUS;
    logic               result_stall = 1'b0;
    logic               item_stall;
    logic               result_valid;
    logic [2:0]         status;
    logic               location_open;
    logic               maze_complete;

    // shadow of the carver state
    bit passage [LOC_COUNT];
    int group_of [LOC_COUNT];
    int merges_made;

    maze_req_t   pending_items [$];
    maze_reply_t pending_replies [$];
    maze_req_t   offered_req;
    maze_reply_t got_reply;

    int          total_items;
    int          items_taken = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          send_gap = 0;
    int          recv_hold_left = 0;
    int          recv_hold;
    int          cycle_count = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    grid_maze_kruskal_carver_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .direction     (direction),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .location_open (location_open),
        .maze_complete (maze_complete)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit on_grid(int r, int c);
        return r >= 0 && r < GRID_SIDE && c >= 0 && c < GRID_SIDE;
    endfunction

    // idle cycles before the next beat, with stretches of back-to-back beats
    function automatic int idle_draw(ref bit burst);
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic maze_reply_t maze_apply(maze_req_t rq);
        maze_reply_t rp;
        int r, c, dr, dc, wr, wc, br, bc, la, lb, hi, lo;
        rp.status        = ST_CARVED;
        rp.location_open = 1'b0;
        r = rq.row;
        c = rq.col;
        if (rq.op == OP_READ)
        begin
            if (on_grid(r, c))
                rp.location_open = passage[r * GRID_SIDE + c];
            else
                rp.status = ST_OUT_OF_BOUNDS;
        end
        else if (!on_grid(r, c) || (r % 2) != 0 || (c % 2) != 0)
        begin
            rp.status = ST_NOT_CELL;
        end
        else
        begin
            dr = 0;
            dc = 0;
            case (rq.dir)
                DIR_ROW_PLUS:  dr = 1;
                DIR_COL_PLUS:  dc = 1;
                DIR_ROW_MINUS: dr = -1;
                default:       dc = -1;
            endcase
            wr = r + dr;
            wc = c + dc;
            br = wr + dr;
            bc = wc + dc;
            if (!on_grid(wr, wc) || !on_grid(br, bc))
                rp.status = ST_OUT_OF_BOUNDS;
            else if (passage[wr * GRID_SIDE + wc])
                rp.status = ST_WALL_OPEN;
            else
            begin
                la = group_of[r * GRID_SIDE + c];
                lb = group_of[br * GRID_SIDE + bc];
                if (la == lb)
                    rp.status = ST_SAME_GROUP;
                else
                begin
                    hi = (la > lb) ? la : lb;
                    lo = (la > lb) ? lb : la;
                    for (int i = 0; i < LOC_COUNT; i++)
                        if (group_of[i] == lo)
                            group_of[i] = hi;
                    group_of[wr * GRID_SIDE + wc] = hi;
                    passage[wr * GRID_SIDE + wc]  = 1'b1;
                    merges_made++;
                end
            end
        end
        rp.maze_complete = (merges_made >= CELL_COUNT - 1);
        return rp;
    endfunction

    task automatic push_req(input logic o, input int r, input int c, input int d,
                            input bit drain);
        maze_req_t rq;
        rq.op    = o;
        rq.row   = COORD_W'(r);
        rq.col   = COORD_W'(c);
        rq.dir   = 2'(d);
        rq.drain = drain;
        pending_items = {pending_items, rq};
    endtask

    // driver: offers beats from the pending queue, predicts on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                pending_replies = {pending_replies, maze_apply(offered_req)};
                items_taken <= items_taken + 1;
            end
            if (item_valid && item_stall)
            begin
                // stalled beat stays as it is
            end
            else if (send_gap != 0)
            begin
                send_gap   <= send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0 && (!pending_items[0].drain ||
                     (!item_valid && items_taken == results_seen)))
            begin
                offered_req = pending_items.pop_front();
                op          <= offered_req.op;
                cell_row    <= offered_req.row;
                cell_col    <= offered_req.col;
                direction   <= offered_req.dir;
                item_valid  <= 1'b1;
                send_gap    <= idle_draw(send_burst);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // monitor: takes result beats and checks them in order
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall   <= 1'b0;
            recv_hold_left <= 0;
        end
        else if (result_valid && !result_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                got_reply = pending_replies.pop_front();
                if (status !== got_reply.status)
                begin
                    $error("status: expected %0d, actual %0d", got_reply.status, status);
                    fail_count++;
                end
                if (location_open !== got_reply.location_open)
                begin
                    $error("location_open: expected %0d, actual %0d",
                           got_reply.location_open, location_open);
                    fail_count++;
                end
                if (maze_complete !== got_reply.maze_complete)
                begin
                    $error("maze_complete: expected %0d, actual %0d",
                           got_reply.maze_complete, maze_complete);
                    fail_count++;
                end
            end
            results_seen <= results_seen + 1;
            // long hold-off lets the carver back up into its input
            if (results_seen == 60 || results_seen == 400)
                recv_hold = LONG_HOLD;
            else
                recv_hold = idle_draw(recv_burst);
            recv_hold_left <= recv_hold;
            result_stall   <= (recv_hold != 0);
        end
        else if (recv_hold_left != 0)
        begin
            recv_hold_left <= recv_hold_left - 1;
            result_stall   <= (recv_hold_left != 1);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("grid_maze_kruskal_carver_unit test failed");
            $finish;
        end
    end

    initial
    begin
        maze_req_t walls [$];
        maze_req_t tmp;
        int        next_label;
        int        j;

        next_label = 0;
        for (int r = 0; r < GRID_SIDE; r++)
            for (int c = 0; c < GRID_SIDE; c++)
                if ((r % 2) == 0 && (c % 2) == 0)
                begin
                    passage[r * GRID_SIDE + c]  = 1'b1;
                    group_of[r * GRID_SIDE + c] = next_label;
                    next_label++;
                end
                else
                begin
                    passage[r * GRID_SIDE + c]  = 1'b0;
                    group_of[r * GRID_SIDE + c] = -1;
                end
        merges_made = 0;

        // directed: reads, edges of the fields, every reject and a few merges
        push_req(OP_READ,  0,  0, DIR_ROW_PLUS,  1'b0);
        push_req(OP_READ,  0,  1, DIR_COL_PLUS,  1'b0);
        push_req(OP_READ,  31, 5, DIR_ROW_MINUS, 1'b0);
        push_req(OP_READ,  5, 31, DIR_COL_MINUS, 1'b0);
        push_req(OP_READ,  31, 31, DIR_COL_MINUS, 1'b0);
        push_req(OP_CARVE, 1,  0, DIR_ROW_PLUS,  1'b0);
        push_req(OP_CARVE, 0,  1, DIR_COL_PLUS,  1'b0);
        push_req(OP_CARVE, 31, 0, DIR_ROW_PLUS,  1'b0);
        push_req(OP_CARVE, 20, 31, DIR_COL_MINUS, 1'b0);
        push_req(OP_CARVE, 31, 31, DIR_ROW_MINUS, 1'b0);
        push_req(OP_CARVE, 30, 30, DIR_ROW_PLUS,  1'b0);
        push_req(OP_CARVE, 30, 30, DIR_COL_PLUS,  1'b0);
        push_req(OP_CARVE, 0,  0, DIR_ROW_MINUS, 1'b0);
        push_req(OP_CARVE, 0,  0, DIR_COL_MINUS, 1'b0);
        push_req(OP_CARVE, 0,  0, DIR_ROW_PLUS,  1'b0);
        push_req(OP_CARVE, 2,  0, DIR_ROW_MINUS, 1'b0);
        push_req(OP_CARVE, 0,  0, DIR_COL_PLUS,  1'b0);
        push_req(OP_CARVE, 2,  0, DIR_COL_PLUS,  1'b0);
        push_req(OP_CARVE, 0,  2, DIR_ROW_PLUS,  1'b0);
        push_req(OP_READ,  1,  0, DIR_ROW_PLUS,  1'b0);
        push_req(OP_CARVE, 28, 30, DIR_ROW_PLUS, 1'b0);
        push_req(OP_CARVE, 30, 28, DIR_COL_PLUS, 1'b0);
        push_req(OP_CARVE, 30, 30, DIR_ROW_MINUS, 1'b0);
        push_req(OP_CARVE, 30, 30, DIR_COL_MINUS, 1'b0);
        push_req(OP_READ,  30, 29, DIR_ROW_PLUS, 1'b0);

        // random: every wall once in shuffled order, from either side
        for (int r = 0; r < GRID_SIDE; r += 2)
            for (int c = 0; c < GRID_SIDE; c += 2)
            begin
                tmp.op    = OP_CARVE;
                tmp.row   = COORD_W'(r);
                tmp.col   = COORD_W'(c);
                tmp.drain = 1'b0;
                if (r + 2 < GRID_SIDE)
                begin
                    tmp.dir = DIR_ROW_PLUS;
                    walls = {walls, tmp};
                end
                if (c + 2 < GRID_SIDE)
                begin
                    tmp.dir = DIR_COL_PLUS;
                    walls = {walls, tmp};
                end
            end
        for (int i = walls.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = walls[i];
            walls[i] = walls[j];
            walls[j] = tmp;
        end
        for (int i = 0; i < walls.size(); i++)
        begin
            tmp = walls[i];
            if ($urandom_range(0, 1) == 1)
            begin
                if (tmp.dir == DIR_ROW_PLUS)
                begin
                    tmp.row = COORD_W'(tmp.row + 2);
                    tmp.dir = DIR_ROW_MINUS;
                end
                else
                begin
                    tmp.col = COORD_W'(tmp.col + 2);
                    tmp.dir = DIR_COL_MINUS;
                end
            end
            tmp.drain = (i == 0 || i == 240);
            pending_items = {pending_items, tmp};
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_req(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 3), 1'b0);
                    1: push_req(OP_CARVE, $urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 3), 1'b0);
                    default: push_req(OP_CARVE, 2 * $urandom_range(0, 15),
                                      2 * $urandom_range(0, 15), $urandom_range(0, 3), 1'b0);
                endcase
            end
        end
        // reads of the finished maze
        for (int i = 0; i < 16; i++)
            push_req(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 3), i == 0);
        total_items = pending_items.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (items_taken == total_items && results_seen == total_items);
        repeat (300) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_replies.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("grid_maze_kruskal_carver_unit test passed");
        else
            $display("grid_maze_kruskal_carver_unit test failed");
        $finish;
    end

endmodule

// File: grid_maze_kruskal_carver_unit.f
rtl/core/gmkc_pkg.sv
rtl/core/gmkc_ctrl.sv
rtl/core/gmkc_datapath.sv
rtl/core/grid_maze_kruskal_carver_unit.sv
verif/testbench.sv
